// ===== rtl/vcc_pkg.sv =====
package vcc_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;

  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032875;
  localparam logic [30:0] SIDE_MAX  = '1;
  localparam logic [14:0] FOV_RESET = 15'd16384;
  localparam logic [22:0] FAR_RESET = 23'd25600;

  localparam logic [7:0] REG_FOV = 8'd0;
  localparam logic [7:0] REG_FAR = 8'd1;

  localparam logic [31:0] ATAN [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
    logic               neg;
  } cordic_t;

  typedef struct packed {
    logic busy;
    logic sat;
  } side_status_t;

  function automatic cordic_t cordic_init(input logic [31:0] phase, input logic [31:0] qmask);
    logic [31:0] r;
    logic [31:0] d;
    cordic_t c;
    r = phase & qmask;
    d = r - 32'h40000000;
    c.neg = ~d[31];
    if (c.neg) begin
      r = r + 32'h80000000;
    end
    c.x = CORDIC_GAIN;
    c.y = '0;
    c.z = $signed({r[31], r});
    return c;
  endfunction

  function automatic cordic_t cordic_step(input cordic_t a, input logic [4:0] i);
    cordic_t r;
    logic signed [32:0] sx;
    logic signed [32:0] sy;
    logic signed [32:0] at;
    sx = a.x >>> i;
    sy = a.y >>> i;
    at = $signed({1'b0, ATAN[i]});
    r.neg = a.neg;
    if (a.z >= 0) begin
      r.x = a.x - sy;
      r.y = a.y + sx;
      r.z = a.z - at;
    end else begin
      r.x = a.x + sy;
      r.y = a.y - sx;
      r.z = a.z + at;
    end
    return r;
  endfunction

  function automatic logic signed [36:0] round_q30(input logic signed [66:0] p);
    logic signed [66:0] t;
    if (p >= 0) begin
      t = (p + 67'sd536870912) >>> 30;
    end else begin
      t = -((-p + 67'sd536870912) >>> 30);
    end
    return t[36:0];
  endfunction

  // bit 24 is the clip flag
  function automatic logic [24:0] clamp24(input logic signed [37:0] v);
    logic [24:0] r;
    if (v > 38'sd8388607) begin
      r = {1'b1, 24'h7FFFFF};
    end else if (v < -38'sd8388608) begin
      r = {1'b1, 24'h800000};
    end else begin
      r = {1'b0, v[23:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/vcc_cordic_pipe.sv =====
module vcc_cordic_pipe #(
  parameter int CORDIC_STAGES = vcc_pkg::CORDIC_STAGES
) (
  input  logic            clk,
  input  logic            en,
  input  vcc_pkg::cordic_t din,
  output vcc_pkg::cordic_t dout
);

  vcc_pkg::cordic_t st [CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= vcc_pkg::cordic_step(din, 5'd0);
      for (int k = 1; k < CORDIC_STAGES; k++) begin
        st[k] <= vcc_pkg::cordic_step(st[k-1], 5'(k));
      end
    end
  end

  assign dout = st[CORDIC_STAGES-1];

endmodule

// ===== rtl/vcc_side_unit.sv =====
module vcc_side_unit #(
  parameter int ANGLE_BITS    = vcc_pkg::ANGLE_BITS,
  parameter int CORDIC_STAGES = vcc_pkg::CORDIC_STAGES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_index,
  input  logic [22:0]           cfg_data,
  output logic [22:0]           far,
  output logic [14:0]           fov,
  output logic [30:0]           side_len,
  output vcc_pkg::side_status_t status
);

  localparam logic [31:0] QMASK = ~(32'hFFFFFFFF >> ANGLE_BITS);
  localparam logic [5:0]  ROT_LAST = 6'(CORDIC_STAGES - 1);
  localparam logic [5:0]  DIV_FIRST = 6'd52;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROT, ST_CHECK, ST_DIV, ST_DONE
  } state_t;

  state_t           state;
  vcc_pkg::cordic_t rot;
  logic [5:0]       cnt;
  logic [31:0]      rem;
  logic [52:0]      dvd;
  logic [52:0]      quo;
  logic             sat;

  logic [32:0] r2;
  logic        ge;
  logic [32:0] diff;

  assign r2   = {rem, dvd[52]};
  assign ge   = r2 >= rot.x[32:0];
  assign diff = r2 - rot.x[32:0];

  assign cfg_ready   = 1'b1;
  assign status.busy = (state != ST_IDLE);
  assign status.sat  = sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      fov   <= vcc_pkg::FOV_RESET;
      far   <= vcc_pkg::FAR_RESET;
      sat   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        vcc_pkg::REG_FOV: fov <= cfg_data[14:0];
        vcc_pkg::REG_FAR: far <= cfg_data;
        default: ;
      endcase
      state <= ST_LOAD;
    end else begin
      case (state)
        ST_LOAD: begin
          rot   <= vcc_pkg::cordic_init({2'b00, fov, 15'b0}, QMASK);
          cnt   <= '0;
          state <= ST_ROT;
        end
        ST_ROT: begin
          rot <= vcc_pkg::cordic_step(rot, cnt[4:0]);
          cnt <= cnt + 6'd1;
          if (cnt == ROT_LAST) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (rot.x <= 0) begin
            side_len <= vcc_pkg::SIDE_MAX;
            sat      <= 1'b1;
            state    <= ST_IDLE;
          end else begin
            rem   <= '0;
            dvd   <= {far, 30'b0};
            quo   <= '0;
            cnt   <= DIV_FIRST;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= ge ? diff[31:0] : r2[31:0];
          quo <= {quo[51:0], ge};
          dvd <= {dvd[51:0], 1'b0};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (|quo[52:31]) begin
            side_len <= vcc_pkg::SIDE_MAX;
            sat      <= 1'b1;
          end else begin
            side_len <= quo[30:0];
            sat      <= 1'b0;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/view_cone_corner_points.sv =====
// view cone corner points
// s_tdata carries one camera update per beat; m_tdata carries the three corners
// (head, left, right) of the view cone, with m_tuser set when anything saturated.
// cfg channel: index 0 writes the field of view, index 1 the far distance.
// an item enters every cycle while s_tready is high; it passes the input register, one
// register per cordic stage, the multiply register and the round and clamp register.
// after reset and after every configuration write the side length is recomputed by a
// separate iterative cordic and a bit-serial divider, and s_tready stays low until that
// is done. config writes are always taken.
// when m_tvalid is high and m_tready is low the whole pipeline holds; beats already inside
// are kept and s_tready drops until the output beat is taken.
module view_cone_corner_points #(
  parameter int ANGLE_BITS    = vcc_pkg::ANGLE_BITS,
  parameter int CORDIC_STAGES = vcc_pkg::CORDIC_STAGES
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [63:0]   s_tdata,   // pos_x, pos_y, view_angle
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [143:0]  m_tdata,   // head_x, head_y, left_x, left_y, right_x, right_y
  output logic [0:0]    m_tuser,   // clipped
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_index,
  input  logic [22:0]   cfg_data
);

  localparam logic [31:0] QMASK = ~(32'hFFFFFFFF >> ANGLE_BITS);

  logic [22:0]           far;
  logic [14:0]           fov;
  logic [30:0]           side_len;
  vcc_pkg::side_status_t status;

  vcc_side_unit #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_side (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .far      (far),
    .fov      (fov),
    .side_len (side_len),
    .status   (status)
  );

  logic en;
  logic accept;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !status.busy;
  assign accept   = s_tvalid && s_tready;

  // input stage
  logic [31:0] view_ph;
  logic [31:0] half_ph;
  assign view_ph = {s_tdata[63:48], 16'b0};
  assign half_ph = {2'b00, fov, 15'b0};

  vcc_pkg::cordic_t lane_in  [3];
  vcc_pkg::cordic_t lane_out [3];

  logic              sb_valid [CORDIC_STAGES+1];
  logic signed [23:0] sb_px   [CORDIC_STAGES+1];
  logic signed [23:0] sb_py   [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (en && accept) begin
      lane_in[0] <= vcc_pkg::cordic_init(view_ph, QMASK);
      lane_in[1] <= vcc_pkg::cordic_init(view_ph - half_ph, QMASK);
      lane_in[2] <= vcc_pkg::cordic_init(view_ph + half_ph, QMASK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= CORDIC_STAGES; k++) begin
        sb_valid[k] <= 1'b0;
      end
    end else if (en) begin
      sb_valid[0] <= accept;
      for (int k = 1; k <= CORDIC_STAGES; k++) begin
        sb_valid[k] <= sb_valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (accept) begin
        sb_px[0] <= $signed(s_tdata[23:0]);
        sb_py[0] <= $signed(s_tdata[47:24]);
      end
      for (int k = 1; k <= CORDIC_STAGES; k++) begin
        sb_px[k] <= sb_px[k-1];
        sb_py[k] <= sb_py[k-1];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    vcc_cordic_pipe #(.CORDIC_STAGES(CORDIC_STAGES)) u_pipe (
      .clk (clk),
      .en  (en),
      .din (lane_in[l]),
      .dout(lane_out[l])
    );
  end

  // multiply stage
  logic signed [66:0] prod_next [6];
  logic signed [66:0] prod      [6];
  logic               mv;
  logic signed [23:0] mpx;
  logic signed [23:0] mpy;

  always_comb begin
    logic signed [32:0] len;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    for (int l = 0; l < 3; l++) begin
      len = (l == 0) ? $signed({10'b0, far}) : $signed({2'b0, side_len});
      cx  = lane_out[l].neg ? -34'(lane_out[l].x) : 34'(lane_out[l].x);
      cy  = lane_out[l].neg ? -34'(lane_out[l].y) : 34'(lane_out[l].y);
      prod_next[2*l]   = 67'(len) * 67'(cx);
      prod_next[2*l+1] = 67'(len) * 67'(cy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (en) begin
      mv <= sb_valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
      mpx  <= sb_px[CORDIC_STAGES];
      mpy  <= sb_py[CORDIC_STAGES];
    end
  end

  // round, offset and clamp stage
  logic [143:0] tdata_next;
  logic         clip_next;

  always_comb begin
    logic [24:0] cx;
    logic [24:0] cy;
    clip_next = status.sat;
    for (int l = 0; l < 3; l++) begin
      cx = vcc_pkg::clamp24(38'(mpx) + 38'(vcc_pkg::round_q30(prod[2*l])));
      cy = vcc_pkg::clamp24(38'(mpy) - 38'(vcc_pkg::round_q30(prod[2*l+1])));
      tdata_next[48*l +: 24]      = cx[23:0];
      tdata_next[48*l + 24 +: 24] = cy[23:0];
      clip_next = clip_next | cx[24] | cy[24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata    <= tdata_next;
      m_tuser[0] <= clip_next;
    end
  end

`ifndef SYNTHESIS
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !s_tready)
    else $error("input taken right after a config write");

  a_busy_blocks_input: assert property (@(posedge clk)
    status.busy |-> !s_tready)
    else $error("input taken while side length is recomputed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("pipeline not cleared by reset");

  a_valid_advance: assert property (@(posedge clk) disable iff (rst)
    en && sb_valid[CORDIC_STAGES] |=> mv)
    else $error("beat lost between cordic and multiply stage");
`endif

endmodule

// ===== tb/testbench.sv =====
module testbench;

  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic [15:0]        ang;
  } cam_t;

  typedef struct packed {
    logic [143:0] pts;
    logic         clip;
  } cone_t;

  typedef struct {
    logic [23:0]  px;
    logic [23:0]  py;
    logic [15:0]  ang;
    logic         chk;
    logic [143:0] pts;
    logic         clip;
  } row_t;

  localparam longint CYCLE_LIMIT = 400000;
  localparam int SETTLE = 120;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [63:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [143:0] m_tdata;
  logic [0:0] m_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [7:0] cfg_index;
  logic [22:0] cfg_data;

  logic [14:0] fov;
  logic [22:0] far;
  cone_t cone_q[$];
  int errors = 0;
  longint cycles = 0;
  bit stall_en;

  view_cone_corner_points dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd30(longint v);
    if (v >= 0) return (v + (64'sd1 <<< 29)) >>> 30;
    return -((-v + (64'sd1 <<< 29)) >>> 30);
  endfunction

  task automatic rotate(input logic [31:0] ph, output longint c, output longint s);
    logic [31:0] r;
    logic [31:0] d;
    longint x, y, z, nx;
    bit flip;
    r = ph & ~(32'hFFFFFFFF >> vcc_pkg::ANGLE_BITS);
    d = r - 32'h40000000;
    flip = d < 32'h80000000;
    if (flip) r = r + 32'h80000000;
    z = r[31] ? longint'(r) - 64'sd4294967296 : longint'(r);
    x = 652032875;
    y = 0;
    for (int i = 0; i < vcc_pkg::CORDIC_STAGES; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i);
        y = y + shr_floor(x, i);
        z -= longint'(vcc_pkg::ATAN[i]);
      end else begin
        nx = x + shr_floor(y, i);
        y = y - shr_floor(x, i);
        z += longint'(vcc_pkg::ATAN[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic [23:0] sat24(longint v, inout bit clip);
    if (v > 8388607) begin
      clip = 1;
      return 24'h7FFFFF;
    end
    if (v < -8388608) begin
      clip = 1;
      return 24'h800000;
    end
    return v[23:0];
  endfunction

  task automatic point(input longint len, input logic [31:0] ph, input longint px,
                       input longint py, output logic [47:0] xy, inout bit clip);
    longint c, s;
    rotate(ph, c, s);
    xy[23:0] = sat24(px + rnd30(len * c), clip);
    xy[47:24] = sat24(py - rnd30(len * s), clip);
  endtask

  task automatic cone_corners(input cam_t cam, output cone_t res);
    logic [31:0] view, half;
    longint px, py, ch, sh, side;
    logic [47:0] hp, lp, rp;
    bit clip;
    clip = 0;
    px = cam.px;
    py = cam.py;
    view = {cam.ang, 16'h0};
    half = {fov, 15'h0};
    point(longint'(far), view, px, py, hp, clip);
    rotate(half, ch, sh);
    if (ch <= 0) begin
      side = 64'sd2147483647;
      clip = 1;
    end else begin
      side = (longint'(far) <<< 30) / ch;
      if (side > 64'sd2147483647) begin
        side = 64'sd2147483647;
        clip = 1;
      end
    end
    point(side, view - half, px, py, lp, clip);
    point(side, view + half, px, py, rp, clip);
    res.pts = {rp, lp, hp};
    res.clip = clip;
  endtask

  task automatic idle_cycles(int n);
    repeat (n) @(negedge clk);
  endtask

  task automatic send_cam(input cam_t cam, input bit chk, input cone_t want);
    cone_t res;
    int gap;
    gap = stall_en ? int'($urandom_range(0, 11)) : 0;
    if (gap > 0) begin
      s_tvalid <= 0;
      idle_cycles(gap);
    end
    cone_corners(cam, res);
    if (chk && res != want)
      $display("%0t directed row disagrees with model: %h vs %h", $time, want, res);
    s_tvalid <= 1;
    s_tdata <= {cam.ang, cam.py, cam.px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    cone_q = {cone_q, (chk ? want : res)};
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [22:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == vcc_pkg::REG_FOV) fov = val[14:0];
    else if (idx == vcc_pkg::REG_FAR) far = val;
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (cone_q.size() != 0) @(negedge clk);
    idle_cycles(30);
  endtask

  always @(negedge clk) begin
    if (rst || !stall_en) m_tready <= 1;
    else m_tready <= ($urandom_range(0, 11) == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    cone_t got, want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      got.pts = m_tdata;
      got.clip = m_tuser[0];
      if (cone_q.size() == 0) begin
        $display("%0t unexpected beat %h", $time, got);
        errors++;
      end else begin
        want = cone_q.pop_front();
        for (int k = 0; k < 6; k++)
          if (got.pts[24*k +: 24] != want.pts[24*k +: 24]) begin
            $display("%0t corner field %0d expected %h actual %h", $time, k,
                     want.pts[24*k +: 24], got.pts[24*k +: 24]);
            errors++;
          end
        if (got.clip != want.clip) begin
          $display("%0t clipped expected %b actual %b", $time, want.clip, got.clip);
          errors++;
        end
      end
    end
  end

  row_t rows[] = '{
    '{24'h000000, 24'h000000, 16'h0000, 0, '0, 0},
    '{24'h7FFFFF, 24'h800000, 16'h0000, 0, '0, 0},
    '{24'h7FFFFF, 24'h7FFFFF, 16'h8000, 0, '0, 0},
    '{24'h800000, 24'h800000, 16'h4000, 0, '0, 0},
    '{24'h800000, 24'h7FFFFF, 16'hC000, 0, '0, 0},
    '{24'h001234, 24'hFFF000, 16'hFFFF, 0, '0, 0},
    '{24'h000100, 24'h000100, 16'h2000, 0, '0, 0},
    '{24'hABCDEF, 24'h543210, 16'h5555, 0, '0, 0},
    '{24'h000000, 24'h000000, 16'h6000, 0, '0, 0}
  };

  task automatic directed_rows;
    cam_t cam;
    cone_t want;
    foreach (rows[i]) begin
      cam.px = rows[i].px;
      cam.py = rows[i].py;
      cam.ang = rows[i].ang;
      want.pts = rows[i].pts;
      want.clip = rows[i].clip;
      send_cam(cam, rows[i].chk, want);
    end
  endtask

  task automatic random_cams(int n);
    cam_t cam;
    cone_t none;
    none = '0;
    for (int i = 0; i < n; i++) begin
      cam.px = (i % 5 == 0) ? 24'($urandom)
                            : 24'($signed($urandom_range(0, 20000)) - 10000);
      cam.py = (i % 7 == 0) ? 24'($urandom)
                            : 24'($signed($urandom_range(0, 20000)) - 10000);
      cam.ang = 16'($urandom);
      send_cam(cam, 0, none);
    end
  endtask

  initial begin
    logic [14:0] fovs[6] = '{15'd0, 15'd32767, 15'd16384, 15'd1, 15'd30000, 15'd8000};
    logic [22:0] fars[6] = '{23'd0, 23'h7FFFFF, 23'd25600, 23'd256, 23'd4000000, 23'd100};
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    stall_en = 0;
    fov = vcc_pkg::FOV_RESET;
    far = vcc_pkg::FAR_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;
    directed_rows();
    stall_en = 1;
    random_cams(150);
    drain();
    write_reg(8'd7, 23'h7FFFFF);
    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(vcc_pkg::REG_FOV, {8'h0, fovs[p]} | (23'($urandom) & 23'h7F8000));
      write_reg(vcc_pkg::REG_FAR, fars[p]);
      stall_en = p % 2;
      directed_rows();
      random_cams(110);
    end
    drain();
    idle_cycles(SETTLE);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
